[hdl/ddrc_pkg.sv]
// Shared types and constants for the debounced distance range classifier.
// Depends on nothing; every other file of the block imports it.
package ddrc_pkg;

    // Range codes carried on range_code.
    localparam logic [2:0] CODE_UNKNOWN  = 3'd0;
    localparam logic [2:0] CODE_CRITICAL = 3'd1;
    localparam logic [2:0] CODE_CLOSE    = 3'd2;
    localparam logic [2:0] CODE_NEAR     = 3'd3;
    localparam logic [2:0] CODE_FAR      = 3'd4;
    localparam logic [2:0] CODE_CLEAR    = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_LIMIT_CRITICAL = 3'd0;
    localparam logic [2:0] REG_LIMIT_CLOSE    = 3'd1;
    localparam logic [2:0] REG_LIMIT_NEAR     = 3'd2;
    localparam logic [2:0] REG_LIMIT_FAR      = 3'd3;
    localparam logic [2:0] REG_CONFIRM_COUNT  = 3'd4;
    localparam logic [2:0] REG_RAW_MODE       = 3'd5;
    localparam logic [2:0] REG_URGENT_POST    = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [15:0] RESET_LIMIT_CRITICAL = 16'd20;
    localparam logic [15:0] RESET_LIMIT_CLOSE    = 16'd50;
    localparam logic [15:0] RESET_LIMIT_NEAR     = 16'd100;
    localparam logic [15:0] RESET_LIMIT_FAR      = 16'd200;
    localparam logic [7:0]  RESET_CONFIRM_COUNT  = 8'd3;

    // Largest value of the confirmation counter.
    localparam logic [7:0] MATCH_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] limit_critical;
        logic [15:0] limit_close;
        logic [15:0] limit_near;
        logic [15:0] limit_far;
        logic [7:0]  confirm_count;
        logic        raw_mode;
        logic        urgent_post;
    } cfg_t;

    // Control from the top level to the tracking logic.
    typedef struct packed {
        logic advance;
        logic clear;
    } track_ctrl_t;

endpackage

[hdl/ddrc_cfg.sv]
// Configuration register file of the range classifier.
// Depends on ddrc_pkg for the register indexes, reset values and cfg_t.
module ddrc_cfg
    import ddrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg,
    output logic        cfg_clear
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one write; an index beyond the list changes nothing.
    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_clear = 1'b0;
        if (cfg_we)
        begin
            cfg_clear = 1'b1;
            unique case (cfg_index)
                REG_LIMIT_CRITICAL: cfg_next.limit_critical = cfg_wdata;
                REG_LIMIT_CLOSE:    cfg_next.limit_close    = cfg_wdata;
                REG_LIMIT_NEAR:     cfg_next.limit_near     = cfg_wdata;
                REG_LIMIT_FAR:      cfg_next.limit_far      = cfg_wdata;
                REG_CONFIRM_COUNT:  cfg_next.confirm_count  = cfg_wdata[7:0];
                REG_RAW_MODE:       cfg_next.raw_mode       = cfg_wdata[0];
                REG_URGENT_POST:    cfg_next.urgent_post    = cfg_wdata[0];
                default:            cfg_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_critical <= RESET_LIMIT_CRITICAL;
            cfg_reg.limit_close    <= RESET_LIMIT_CLOSE;
            cfg_reg.limit_near     <= RESET_LIMIT_NEAR;
            cfg_reg.limit_far      <= RESET_LIMIT_FAR;
            cfg_reg.confirm_count  <= RESET_CONFIRM_COUNT;
            cfg_reg.raw_mode       <= 1'b0;
            cfg_reg.urgent_post    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/ddrc_classify.sv]
// Range classification of one distance sample against the four limits.
// Depends on ddrc_pkg for the range codes and cfg_t.
module ddrc_classify
    import ddrc_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [15:0] distance_cm,
    input  logic        measure_ok,
    output logic [2:0]  code,
    output logic [15:0] shown_cm
);

    // Limits are tested in order; the first one not exceeded wins.
    always_comb
    begin
        if (!measure_ok)
            code = CODE_CLEAR;
        else if (distance_cm <= cfg.limit_critical)
            code = CODE_CRITICAL;
        else if (distance_cm <= cfg.limit_close)
            code = CODE_CLOSE;
        else if (distance_cm <= cfg.limit_near)
            code = CODE_NEAR;
        else if (distance_cm <= cfg.limit_far)
            code = CODE_FAR;
        else
            code = CODE_CLEAR;
    end

    // A failed measurement is shown as distance zero.
    assign shown_cm = measure_ok ? distance_cm : 16'd0;

endmodule

[hdl/ddrc_track.sv]
// Confirmation debounce: pending range, confirmed range and match counter.
// Depends on ddrc_pkg for the range codes, cfg_t and track_ctrl_t.
module ddrc_track
    import ddrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  track_ctrl_t ctrl,
    input  logic [2:0]  code,
    output logic        report
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic [2:0] confirmed_reg;
    logic [2:0] confirmed_next;
    logic [7:0] match_reg;
    logic [7:0] match_next;
    logic [7:0] match_inc;

    // Counter after a matching sample, held at its maximum.
    assign match_inc = (match_reg == MATCH_MAX) ? match_reg : match_reg + 8'd1;

    // Next tracking state and the report decision for the item in flight.
    always_comb
    begin
        pending_next   = pending_reg;
        confirmed_next = confirmed_reg;
        match_next     = match_reg;
        report         = 1'b0;
        if (ctrl.clear)
        begin
            pending_next   = CODE_UNKNOWN;
            confirmed_next = CODE_UNKNOWN;
            match_next     = 8'd0;
        end
        else if (ctrl.advance)
        begin
            if (cfg.raw_mode)
            begin
                report = 1'b1;
            end
            else if (code == pending_reg)
            begin
                match_next = match_inc;
                if (match_inc >= cfg.confirm_count && code != confirmed_reg)
                begin
                    confirmed_next = code;
                    match_next     = 8'd0;
                    report         = 1'b1;
                end
            end
            else
            begin
                pending_next = code;
                match_next   = 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= CODE_UNKNOWN;
            confirmed_reg <= CODE_UNKNOWN;
            match_reg     <= 8'd0;
        end
        else
        begin
            pending_reg   <= pending_next;
            confirmed_reg <= confirmed_next;
            match_reg     <= match_next;
        end
    end

endmodule

[hdl/debounced_distance_range_classifier_core.sv]
// Top level of the debounced distance range classifier.
// Depends on ddrc_pkg, ddrc_cfg, ddrc_classify and ddrc_track.
//
// Channel   Signals                                   Direction
// -------   ---------------------------------------   ---------
// in        in_valid, in_ready, distance_cm,           sink
//           measure_ok
// out       out_valid, out_ready, range_code,          source
//           reported_cm, urgent
// cfg       cfg_we, cfg_index, cfg_wdata               sink, write only
//
// One item is accepted per cycle while in_ready is high. The sample is classified
// on entry and held in an input register; when it advances, the debounce logic
// decides and a reported item is loaded into the output register.
// An item that causes no report retires without using the output register.
// Reset clears all valid bits and the tracking state. While the output register
// is stalled the input register holds, and in_ready drops only when both are full.
module debounced_distance_range_classifier_core
    import ddrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] distance_cm,
    input  logic        measure_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  range_code,
    output logic [15:0] reported_cm,
    output logic        urgent,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t        cfg;
    logic        cfg_clear;
    logic [2:0]  class_code;
    logic [15:0] class_cm;
    logic        report;
    track_ctrl_t track_ctrl;

    logic        s1_valid_reg;
    logic [2:0]  s1_code_reg;
    logic [15:0] s1_cm_reg;
    logic        out_valid_reg;
    logic [2:0]  out_code_reg;
    logic [15:0] out_cm_reg;
    logic        out_urgent_reg;
    logic        advance;
    logic        in_fire;

    ddrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    ddrc_classify u_classify (
        .cfg         (cfg),
        .distance_cm (distance_cm),
        .measure_ok  (measure_ok),
        .code        (class_code),
        .shown_cm    (class_cm)
    );

    // The held item moves on when the output register is free or being drained.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign track_ctrl.advance = advance;
    assign track_ctrl.clear   = cfg_clear;

    ddrc_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .ctrl   (track_ctrl),
        .code   (s1_code_reg),
        .report (report)
    );

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Input register payload: classified range and shown distance.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_code_reg <= class_code;
            s1_cm_reg   <= class_cm;
        end
    end

    // Output register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= report;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload, loaded only for a reported item.
    always_ff @(posedge clk)
    begin
        if (advance && report)
        begin
            out_code_reg   <= s1_code_reg;
            out_cm_reg     <= s1_cm_reg;
            out_urgent_reg <= cfg.urgent_post;
        end
    end

    assign out_valid   = out_valid_reg;
    assign range_code  = out_code_reg;
    assign reported_cm = out_cm_reg;
    assign urgent      = out_urgent_reg;

endmodule

[hdl/ddrc_checker.sv]
// Port-level checks for the debounced distance range classifier.
// Depends on ddrc_pkg for the range codes; bound to the top level below.
module ddrc_checker
    import ddrc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  range_code,
    input logic [15:0] reported_cm,
    input logic        urgent
);

    // A stalled result item keeps its valid and payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(range_code)
            && $stable(reported_cm) && $stable(urgent))
    else $error("stalled result item changed");

    // A reported range is never unknown and never beyond clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> range_code != CODE_UNKNOWN && range_code <= CODE_CLEAR)
    else $error("result item carries an invalid range code");

    // Input back-pressure only ever comes from a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled while the output register is empty");

    // A clock edge seen in reset leaves the output register empty.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result item valid after a reset edge");

endmodule

bind debounced_distance_range_classifier_core ddrc_checker u_ddrc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .range_code  (range_code),
    .reported_cm (reported_cm),
    .urgent      (urgent)
);
